### design/double_ended_queue_core_defines.svh
// Assertion macros shared by the double-ended queue checker.
`ifndef DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DEQ_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed: same-cycle property");

// Consequent checked in the cycle after the antecedent.
`define DEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed: next-cycle property");

`endif

### design/deq_pkg.sv
// Shared types and constants of the double-ended queue.
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;
   localparam int COUNT_OUT_W   = 5;

   typedef enum logic [1:0] {
      ACT_PUSH_FRONT = 2'd0,
      ACT_PUSH_TAIL  = 2'd1,
      ACT_POP_FRONT  = 2'd2,
      ACT_POP_TAIL   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

### design/deq_ram.sv
// Single-port entry store with registered read data.
module deq_ram #(
   parameter int DEPTH  = deq_pkg::DEPTH_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         addr,
   input  logic [deq_pkg::WORD_W-1:0] wr_data,
   output logic [deq_pkg::WORD_W-1:0] rd_data
);

   logic [deq_pkg::WORD_W-1:0] entries_ff [DEPTH];
   logic [deq_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/double_ended_queue_core.sv
// Top level of the double-ended queue of signed 32-bit words.
//
// A request carries an action in req_tuser (push front, push tail, pop front,
// pop tail) and a word in req_tdata. Every request gives exactly one response:
// the popped word (all ones on pushes and on a pop from an empty queue), a
// status in rsp_tuser (done, pop on empty, push on full rejected) and the
// number of words held after the action. Words live in a ring of DEPTH
// entries in one single-port memory; the front word sits at the head pointer
// and the tail word count-1 places after it, so no word is ever moved.
// Rate: one request per cycle sustained while each response is taken. The
// pointer and count update at acceptance and the single memory access of that
// request (write on a push, read on a pop) is issued in the same cycle; the
// response appears in the next cycle from the memory's read register.
// req_tready follows the output register: it is high when no response is held
// or the held one is taken in this cycle. No clearing pass runs after reset;
// entries are read only after a push has written them.
module double_ended_queue_core #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] push_value
   input  logic [1:0]  req_tuser,   // [1:0] action
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] pop_value, [36:32] entry_count, rest zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;

   localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [SUM_W-1:0]  DEPTH_SUM  = SUM_W'(DEPTH);

   // pointer state
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // response register
   logic                             rsp_valid_ff, rsp_valid_in;
   deq_pkg::status_type              status_ff, status_in;
   logic [deq_pkg::COUNT_OUT_W-1:0]  count_out_ff;
   logic                             pop_ok_ff, pop_ok_in;

   // memory access of the accepted request
   logic                        mem_wr, mem_rd;
   logic [ADDR_W-1:0]           mem_addr;
   logic [deq_pkg::WORD_W-1:0]  mem_rd_data;

   logic                 req_accept;
   deq_pkg::action_type  act;
   logic                 is_full, is_empty;
   logic [ADDR_W-1:0]    head_dec, head_inc;
   logic [SUM_W-1:0]     tail_sum, tail_sum_m1, push_tail_pos, pop_tail_pos;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign act        = deq_pkg::action_type'(req_tuser);

   assign is_full  = (count_ff == FULL_COUNT);
   assign is_empty = (count_ff == '0);

   // ring arithmetic: one compare and subtract, sums stay below 2*DEPTH
   assign head_dec    = (head_ff == '0) ? LAST_POS : head_ff - 1'b1;
   assign head_inc    = (head_ff == LAST_POS) ? '0 : head_ff + 1'b1;
   assign tail_sum    = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_sum_m1 = tail_sum - 1'b1;
   assign push_tail_pos = (tail_sum >= DEPTH_SUM) ? tail_sum - DEPTH_SUM : tail_sum;
   assign pop_tail_pos  = (tail_sum_m1 >= DEPTH_SUM) ? tail_sum_m1 - DEPTH_SUM
                                                     : tail_sum_m1;

   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      mem_addr  = head_ff;
      status_in = deq_pkg::ST_DONE;
      pop_ok_in = 1'b0;
      unique case (act)
         deq_pkg::ACT_PUSH_FRONT: begin
            if (is_full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               head_in  = head_dec;
               mem_addr = head_dec;
               mem_wr   = req_accept;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::ACT_PUSH_TAIL: begin
            if (is_full) begin
               status_in = deq_pkg::ST_FULL;
            end else begin
               mem_addr = push_tail_pos[ADDR_W-1:0];
               mem_wr   = req_accept;
               count_in = count_ff + 1'b1;
            end
         end
         deq_pkg::ACT_POP_FRONT: begin
            if (is_empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               head_in   = head_inc;
               mem_rd    = req_accept;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         deq_pkg::ACT_POP_TAIL: begin
            if (is_empty) begin
               status_in = deq_pkg::ST_EMPTY;
            end else begin
               mem_addr  = pop_tail_pos[ADDR_W-1:0];
               mem_rd    = req_accept;
               pop_ok_in = 1'b1;
               count_in  = count_ff - 1'b1;
            end
         end
         default: begin
            status_in = deq_pkg::ST_DONE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   // payload of the held response; holds while stalled since no request
   // is taken then
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff    <= status_in;
         pop_ok_ff    <= pop_ok_in;
         count_out_ff <= deq_pkg::COUNT_OUT_W'(count_in);
      end
   end

   deq_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (mem_addr),
      .wr_data (req_tdata),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, count_out_ff,
                        (pop_ok_ff ? mem_rd_data : {deq_pkg::WORD_W{1'b1}})};
   assign rsp_tuser  = status_ff;

endmodule

### design/deq_checker.sv
// Port-level checks of the double-ended queue, bound to the top level.
`include "double_ended_queue_core_defines.svh"

module deq_checker #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   localparam logic [4:0] FULL_CNT = 5'(DEPTH);

   logic        rsp_stall;
   logic [41:0] rsp_payload;
   logic        empty_rsp, full_rsp;
   logic        word_all_ones, count_zero, count_full;

   assign rsp_stall     = rsp_tvalid && !rsp_tready;
   assign rsp_payload   = {rsp_tuser, rsp_tdata};
   assign empty_rsp     = rsp_tvalid && (rsp_tuser == deq_pkg::ST_EMPTY);
   assign full_rsp      = rsp_tvalid && (rsp_tuser == deq_pkg::ST_FULL);
   assign word_all_ones = (rsp_tdata[31:0] == 32'hFFFF_FFFF);
   assign count_zero    = (rsp_tdata[36:32] == 5'd0);
   assign count_full    = (rsp_tdata[36:32] == FULL_CNT);

   // a held response keeps its contents
   `DEQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_payload))

   // every accepted request shows its response on the next cycle
   `DEQ_ASSERT_NEXT(a_rsp_follows, clock, reset, req_tvalid && req_tready, rsp_tvalid)

   // pop on empty: all-ones word and an empty count
   `DEQ_ASSERT_SAME(a_empty_rsp, clock, reset, empty_rsp, word_all_ones && count_zero)

   // rejected push: all-ones word and a full count
   `DEQ_ASSERT_SAME(a_full_rsp, clock, reset, full_rsp, word_all_ones && count_full)

endmodule

bind double_ended_queue_core deq_checker #(
   .DEPTH (DEPTH)
) u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### bench/tb_double_ended_queue_core.sv
// Self-checking bench for the double-ended queue core: directed table, random traffic, predictor.
module tb_double_ended_queue_core;

   localparam int RING_DEPTH      = deq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_REQUESTS = 900;
   localparam int LONG_HOLD       = 300;   // receiver hold-off, in cycles
   localparam int IDLE_LIMIT      = 5000;  // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES   = 10;    // quiet time after the last response

   // One response as the checker sees it.
   typedef struct packed {
      logic [31:0]         pop_value;
      deq_pkg::status_type status;
      logic [4:0]          entry_count;
   } deq_response_type;

   // One row of the directed table. typed rows carry their response inline;
   // the others are checked against the predictor.
   typedef struct packed {
      deq_pkg::action_type act;
      logic [31:0]         word;
      logic                typed;
      logic [31:0]         pop_value;
      deq_pkg::status_type status;
      logic [4:0]          entry_count;
   } directed_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] push_value
   logic [1:0]  req_tuser  = deq_pkg::ACT_PUSH_FRONT;   // [1:0] action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] pop_value, [36:32] entry_count, rest zero
   logic [1:0]  rsp_tuser;         // [1:0] status

   always #5 clock = ~clock;

   double_ended_queue_core #(
      .DEPTH(RING_DEPTH)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // ---------------------------------------------------------------------
   // Predictor: a ring of words, the slot of the front word and the count.
   // The tail word sits words_held - 1 slots after the front, modulo depth.
   // ---------------------------------------------------------------------
   logic [31:0] ring_words [RING_DEPTH];
   int unsigned front_slot = 0;
   int unsigned words_held = 0;

   function automatic deq_response_type apply_action(deq_pkg::action_type act,
                                                     logic [31:0] word);
      deq_response_type r;
      int unsigned      slot;
      r.pop_value = '1;   // all ones unless a pop succeeds
      r.status    = deq_pkg::ST_DONE;
      if (act == deq_pkg::ACT_PUSH_FRONT || act == deq_pkg::ACT_PUSH_TAIL) begin
         if (words_held >= RING_DEPTH) begin
            r.status = deq_pkg::ST_FULL;   // rejected, state untouched
         end else begin
            if (act == deq_pkg::ACT_PUSH_FRONT) begin
               front_slot = (front_slot + RING_DEPTH - 1) % RING_DEPTH;
               slot       = front_slot;
            end else begin
               slot = (front_slot + words_held) % RING_DEPTH;
            end
            ring_words[slot] = word;
            words_held++;
         end
      end else begin
         if (words_held == 0) begin
            r.status = deq_pkg::ST_EMPTY;
         end else begin
            if (act == deq_pkg::ACT_POP_FRONT) begin
               slot       = front_slot;
               front_slot = (front_slot + 1) % RING_DEPTH;
            end else begin
               slot = (front_slot + words_held - 1) % RING_DEPTH;
            end
            r.pop_value = ring_words[slot];
            words_held--;
         end
      end
      r.entry_count = 5'(words_held);
      return r;
   endfunction

   // Responses owed by the core, oldest first.
   deq_response_type pending_responses [$];
   int               failures = 0;

   // ---------------------------------------------------------------------
   // Directed table: empty pops, extreme words, head wrap on a front push,
   // fill to full with both ends, pushes on a full queue, then pops at both ends.
   // ---------------------------------------------------------------------
   directed_row_type directed_rows [26] = '{
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY, 5'd0},
      '{deq_pkg::ACT_POP_TAIL,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_EMPTY, 5'd0},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd1},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h8000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd2},
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, deq_pkg::ST_DONE,  5'd1},
      '{deq_pkg::ACT_POP_TAIL,   32'h0000_0000, 1'b1, 32'h8000_0000, deq_pkg::ST_DONE,  5'd0},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd1},
      '{deq_pkg::ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd2},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h5555_5555, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd3},
      '{deq_pkg::ACT_PUSH_FRONT, 32'hAAAA_AAAA, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd4},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h0000_0001, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd5},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd6},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd7},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd8},
      '{deq_pkg::ACT_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd9},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h0F0F_0F0F, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd10},
      '{deq_pkg::ACT_PUSH_TAIL,  32'hF0F0_F0F0, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd11},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h0000_FFFF, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd12},
      '{deq_pkg::ACT_PUSH_TAIL,  32'hFFFF_0000, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd13},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h3333_CCCC, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd14},
      '{deq_pkg::ACT_PUSH_TAIL,  32'hCCCC_3333, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd15},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h8000_0001, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_DONE,  5'd16},
      '{deq_pkg::ACT_PUSH_TAIL,  32'h1111_1111, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_FULL,  5'd16},
      '{deq_pkg::ACT_PUSH_FRONT, 32'h2222_2222, 1'b1, 32'hFFFF_FFFF, deq_pkg::ST_FULL,  5'd16},
      '{deq_pkg::ACT_POP_TAIL,   32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::ST_DONE,  5'd0},
      '{deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0000_0000, deq_pkg::ST_DONE,  5'd0}
   };

   // ---------------------------------------------------------------------
   // Request side. Every task leaves req_tvalid with one NBA per time step.
   // ---------------------------------------------------------------------
   int burst_left   = 0;
   bit hold_off_req = 1'b0;   // asks the receiver for one long stall

   // Offer one request and wait for it to be taken; the expected response is
   // queued at the accepting edge.
   task automatic send_request(input deq_pkg::action_type act, input logic [31:0] word,
                               input logic typed, input deq_response_type typed_rsp);
      deq_response_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= word;
      do @(posedge clock); while (req_tready !== 1'b1);
      predicted = apply_action(act, word);
      pending_responses.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic idle_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Bursts of random length; most bursts are followed by a short gap.
   task automatic pace_sender();
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 6));
      end
      burst_left--;
   endtask

   // Stop offering until every response owed has come back (at least one edge).
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_responses.size() != 0);
   endtask

   // Words lean on the extremes now and then.
   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   initial begin : stimulus
      deq_response_type    typed_rsp;
      deq_pkg::action_type act;
      int                  episode_left;
      int                  push_weight;
      bit                  is_push;
      bit                  at_tail;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         typed_rsp.pop_value   = directed_rows[i].pop_value;
         typed_rsp.status      = directed_rows[i].status;
         typed_rsp.entry_count = directed_rows[i].entry_count;
         pace_sender();
         send_request(directed_rows[i].act, directed_rows[i].word,
                      directed_rows[i].typed, typed_rsp);
      end
      drain_responses();

      // Random part: episodes that lean toward filling, draining or neither,
      // so the count sweeps between empty and full many times.
      episode_left = 0;
      push_weight  = 50;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (episode_left == 0) begin
            episode_left = $urandom_range(20, 60);
            case ($urandom_range(0, 4))
               0: push_weight = 85;
               1: push_weight = 15;
               2: push_weight = 70;
               3: push_weight = 30;
               default: push_weight = 50;
            endcase
         end
         episode_left--;

         // One long receiver stall while requests keep coming: the output
         // register fills and req_tready must drop.
         if (n == 250)
            hold_off_req = 1'b1;
         // One pause with nothing outstanding.
         if (n == 600)
            drain_responses();

         is_push = ($urandom_range(0, 99) < push_weight);
         at_tail = $urandom_range(0, 1);
         act = is_push ? (at_tail ? deq_pkg::ACT_PUSH_TAIL : deq_pkg::ACT_PUSH_FRONT)
                       : (at_tail ? deq_pkg::ACT_POP_TAIL  : deq_pkg::ACT_POP_FRONT);
         pace_sender();
         send_request(act, random_word(), 1'b0, typed_rsp);
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0 && pending_responses.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Response side: stretches of full rate, a rotating stall mask and coin
   // flips, plus the one long hold-off on request.
   // ---------------------------------------------------------------------
   initial begin : receiver
      int         stretch_left;
      int         mode;
      logic [7:0] stall_mask;
      logic       ready_next;

      stretch_left = 0;
      mode         = 0;
      stall_mask   = 8'b1011_0010;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         if (stretch_left == 0) begin
            stretch_left = $urandom_range(20, 80);
            mode         = $urandom_range(0, 2);
         end
         stretch_left--;
         stall_mask = {stall_mask[6:0], stall_mask[7]};
         case (mode)
            0:       ready_next = 1'b1;
            1:       ready_next = stall_mask[0];
            default: ready_next = $urandom_range(0, 1);
         endcase
         rsp_tready <= ready_next;
      end
   end

   // ---------------------------------------------------------------------
   // Checker: each response against the oldest expectation, field by field.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      deq_response_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding: tdata %h tuser %h",
                   rsp_tdata, rsp_tuser);
            failures++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_tdata[31:0] !== want.pop_value) begin
               $error("pop_value: expected %h, got %h", want.pop_value, rsp_tdata[31:0]);
               failures++;
            end
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               failures++;
            end
            if (rsp_tdata[36:32] !== want.entry_count) begin
               $error("entry_count: expected %0d, got %0d",
                      want.entry_count, rsp_tdata[36:32]);
               failures++;
            end
            if (rsp_tdata[39:37] !== 3'b000) begin
               $error("tdata padding: expected 0, got %b", rsp_tdata[39:37]);
               failures++;
            end
         end
      end
   end

   // Watchdog: too long without a handshake on either side ends the run.
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
